>>> src/ssoe_pkg.sv
// ----------------------------------------------------------------------------
// ssoe_pkg: shared types and codes of the sorted set operation engine
// Request and result beat layouts, request and mode codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ssoe_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_DEFAULT = 16;
	localparam int REQ_W         = 3;
	localparam int MODE_W        = 3;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOAD_A = 3'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_B = 3'd1;
	localparam logic [REQ_W-1:0] REQ_RUN    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_MEMBER = 3'd4;

	// operation mode codes
	localparam logic [MODE_W-1:0] MODE_UNION  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INTER  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DIFF   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUBSET = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EQUAL  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PROPER = 3'd5;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     result_flag;
		logic                     empty_result;
		logic                     overflow;
		logic                     is_last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MEMBER,
		ST_RUN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic load_step;
		logic member_step;
		logic run_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic load_done;
		logic member_done;
		logic run_done;
	} sts_t;

endpackage

>>> src/ssoe_ctrl.sv
// ----------------------------------------------------------------------------
// ssoe_ctrl: request sequencer of the sorted set operation engine
// Takes one request beat in idle, then steps the datapath through a load
// scan, a membership scan or a set run until the datapath reports done.
// ----------------------------------------------------------------------------
module ssoe_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [ssoe_pkg::REQ_W-1:0]    req_type,
	input  ssoe_pkg::sts_t                sts,
	output ssoe_pkg::cmd_t                cmd
);

	ssoe_pkg::state_t state_q;
	ssoe_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssoe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ssoe_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (req_type)
						ssoe_pkg::REQ_LOAD_A,
						ssoe_pkg::REQ_LOAD_B: state_nxt = ssoe_pkg::ST_LOAD;
						ssoe_pkg::REQ_RUN:    state_nxt = ssoe_pkg::ST_RUN;
						ssoe_pkg::REQ_MEMBER: state_nxt = ssoe_pkg::ST_MEMBER;
						default:              state_nxt = ssoe_pkg::ST_IDLE;
					endcase
				end
			end
			ssoe_pkg::ST_LOAD: begin
				if (sts.load_done) state_nxt = ssoe_pkg::ST_IDLE;
			end
			ssoe_pkg::ST_MEMBER: begin
				if (sts.member_done) state_nxt = ssoe_pkg::ST_IDLE;
			end
			ssoe_pkg::ST_RUN: begin
				if (sts.run_done) state_nxt = ssoe_pkg::ST_IDLE;
			end
			default: state_nxt = ssoe_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready       = (state_q == ssoe_pkg::ST_IDLE);
		cmd.capture     = req_ready && req_valid;
		cmd.clear       = cmd.capture && (req_type == ssoe_pkg::REQ_CLEAR);
		cmd.load_step   = (state_q == ssoe_pkg::ST_LOAD);
		cmd.member_step = (state_q == ssoe_pkg::ST_MEMBER);
		cmd.run_step    = (state_q == ssoe_pkg::ST_RUN);
	end

endmodule

>>> src/ssoe_dp.sv
// ----------------------------------------------------------------------------
// ssoe_dp: datapath of the sorted set operation engine
// Holds both sorted sets, their counts, the sticky overflow flag and the mode
// register; walks the sets with one pointer each and drives the result beat.
// ----------------------------------------------------------------------------
module ssoe_dp #(
	parameter int DEPTH = ssoe_pkg::DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [ssoe_pkg::MODE_W-1:0]    cfg_data,
	input  ssoe_pkg::req_t                 req_data,
	input  ssoe_pkg::cmd_t                 cmd,
	output ssoe_pkg::sts_t                 sts,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output ssoe_pkg::rsp_t                 rsp_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic signed [ssoe_pkg::DATA_W-1:0] set_a_q [DEPTH];
	logic signed [ssoe_pkg::DATA_W-1:0] set_b_q [DEPTH];
	logic [CW-1:0]                      count_a_q;
	logic [CW-1:0]                      count_b_q;
	logic                               ovf_q;
	logic [ssoe_pkg::MODE_W-1:0]        mode_q;
	logic [ssoe_pkg::REQ_W-1:0]         cur_type_q;
	logic signed [ssoe_pkg::DATA_W-1:0] cur_val_q;
	logic [CW-1:0]                      i_q;
	logic [CW-1:0]                      j_q;
	logic                               pend_q;
	logic signed [ssoe_pkg::DATA_W-1:0] pend_val_q;
	logic                               rsp_valid_q;
	ssoe_pkg::rsp_t                     rsp_q;

	logic signed [ssoe_pkg::DATA_W-1:0] av;
	logic signed [ssoe_pkg::DATA_W-1:0] bv;
	logic                               a_ok;
	logic                               b_ok;
	logic                               lt;
	logic                               gt;
	logic                               step_ok;

	logic                               ld_b;
	logic                               ld_ok;
	logic signed [ssoe_pkg::DATA_W-1:0] ld_v;
	logic                               ld_hit;
	logic                               ld_adv;
	logic                               ld_full;
	logic                               ins_a;
	logic                               ins_b;

	logic                               mem_hit;
	logic                               mem_end;

	logic                               set_mode;
	logic                               run_go;
	logic                               run_emit;
	logic signed [ssoe_pkg::DATA_W-1:0] run_val;
	logic                               run_inc_i;
	logic                               run_inc_j;
	logic                               run_end;
	logic                               run_flag;

	logic                               rsp_we;
	ssoe_pkg::rsp_t                     rsp_nxt;

	// read both sets at their pointers and compare
	always_comb begin
		av      = set_a_q[i_q[IW-1:0]];
		bv      = set_b_q[j_q[IW-1:0]];
		a_ok    = (i_q < count_a_q);
		b_ok    = (j_q < count_b_q);
		lt      = (av < bv);
		gt      = (bv < av);
		step_ok = !rsp_valid_q || rsp_ready;
	end

	// load scan: advance past smaller entries, then insert, drop or flag overflow
	always_comb begin
		ld_b    = (cur_type_q == ssoe_pkg::REQ_LOAD_B);
		ld_ok   = ld_b ? b_ok : a_ok;
		ld_v    = ld_b ? bv : av;
		ld_hit  = ld_ok && (ld_v == cur_val_q);
		ld_adv  = ld_ok && (ld_v < cur_val_q);
		ld_full = ld_b ? (count_b_q >= FULL) : (count_a_q >= FULL);
		ins_a   = cmd.load_step && !ld_adv && !ld_hit && !ld_full && !ld_b;
		ins_b   = cmd.load_step && !ld_adv && !ld_hit && !ld_full && ld_b;
	end

	// membership scan over A
	always_comb begin
		mem_hit = a_ok && (av == cur_val_q);
		mem_end = !a_ok || mem_hit;
	end

	// one merge step of the selected operation
	always_comb begin
		set_mode  = (mode_q == ssoe_pkg::MODE_UNION) || (mode_q == ssoe_pkg::MODE_INTER) ||
			(mode_q == ssoe_pkg::MODE_DIFF);
		run_emit  = 1'b0;
		run_val   = av;
		run_inc_i = 1'b0;
		run_inc_j = 1'b0;
		run_end   = 1'b0;
		run_flag  = 1'b0;
		unique case (mode_q)
			ssoe_pkg::MODE_UNION: begin
				if (!a_ok && !b_ok) begin
					run_end = 1'b1;
				end else if (!b_ok || (a_ok && lt)) begin
					run_emit  = 1'b1;
					run_inc_i = 1'b1;
				end else if (!a_ok || gt) begin
					run_emit  = 1'b1;
					run_val   = bv;
					run_inc_j = 1'b1;
				end else begin
					run_emit  = 1'b1;
					run_inc_i = 1'b1;
					run_inc_j = 1'b1;
				end
			end
			ssoe_pkg::MODE_INTER: begin
				if (!a_ok || !b_ok) begin
					run_end = 1'b1;
				end else if (lt) begin
					run_inc_i = 1'b1;
				end else if (gt) begin
					run_inc_j = 1'b1;
				end else begin
					run_emit  = 1'b1;
					run_inc_i = 1'b1;
					run_inc_j = 1'b1;
				end
			end
			ssoe_pkg::MODE_DIFF: begin
				if (!a_ok) begin
					run_end = 1'b1;
				end else if (!b_ok || lt) begin
					run_emit  = 1'b1;
					run_inc_i = 1'b1;
				end else if (gt) begin
					run_inc_j = 1'b1;
				end else begin
					run_inc_i = 1'b1;
					run_inc_j = 1'b1;
				end
			end
			ssoe_pkg::MODE_SUBSET,
			ssoe_pkg::MODE_EQUAL,
			ssoe_pkg::MODE_PROPER: begin
				if (!a_ok) begin
					// every element of A was found in B
					run_end = 1'b1;
					unique case (mode_q)
						ssoe_pkg::MODE_SUBSET: run_flag = 1'b1;
						ssoe_pkg::MODE_EQUAL:  run_flag = (count_a_q == count_b_q);
						default:               run_flag = (count_b_q > count_a_q);
					endcase
				end else if (!b_ok || lt) begin
					run_end = 1'b1;
				end else if (gt) begin
					run_inc_j = 1'b1;
				end else begin
					run_inc_i = 1'b1;
					run_inc_j = 1'b1;
				end
			end
			default: begin
				run_end = 1'b1;
			end
		endcase
		run_go = cmd.run_step && step_ok;
	end

	// next result beat; an element waits in the pending slot until its successor
	// or the end of the run tells whether it is the last one
	always_comb begin
		rsp_we                = 1'b0;
		rsp_nxt.result_value  = '0;
		rsp_nxt.result_flag   = 1'b0;
		rsp_nxt.empty_result  = 1'b0;
		rsp_nxt.overflow      = ovf_q;
		rsp_nxt.is_last       = 1'b0;
		if (run_go && run_emit && pend_q) begin
			rsp_we               = 1'b1;
			rsp_nxt.result_value = pend_val_q;
		end else if (run_go && run_end) begin
			rsp_we          = 1'b1;
			rsp_nxt.is_last = 1'b1;
			if (!set_mode) begin
				rsp_nxt.result_flag = run_flag;
			end else if (pend_q) begin
				rsp_nxt.result_value = pend_val_q;
			end else begin
				rsp_nxt.empty_result = 1'b1;
			end
		end else if (cmd.member_step && step_ok && mem_end) begin
			rsp_we              = 1'b1;
			rsp_nxt.result_flag = mem_hit;
			rsp_nxt.is_last     = 1'b1;
		end
	end

	// status back to the controller
	always_comb begin
		sts.load_done   = cmd.load_step && !ld_adv;
		sts.member_done = cmd.member_step && step_ok && mem_end;
		sts.run_done    = run_go && run_end;
	end

	// mode register, counts, overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ssoe_pkg::MODE_UNION;
			count_a_q <= '0;
			count_b_q <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (cfg_valid) mode_q <= cfg_data;
			if (cmd.clear) begin
				count_a_q <= '0;
				count_b_q <= '0;
				ovf_q     <= 1'b0;
			end else begin
				if (ins_a) count_a_q <= count_a_q + CW'(1);
				if (ins_b) count_b_q <= count_b_q + CW'(1);
				if (cmd.load_step && !ld_adv && !ld_hit && ld_full) ovf_q <= 1'b1;
			end
		end
	end

	// scan pointers and pending slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				i_q    <= '0;
				j_q    <= '0;
				pend_q <= 1'b0;
			end else begin
				if ((cmd.load_step && ld_adv && !ld_b) ||
					(cmd.member_step && step_ok && !mem_end) ||
					(run_go && run_inc_i)) begin
					i_q <= i_q + CW'(1);
				end
				if ((cmd.load_step && ld_adv && ld_b) || (run_go && run_inc_j)) begin
					j_q <= j_q + CW'(1);
				end
				if (run_go && run_emit) begin
					pend_q <= 1'b1;
				end else if (run_go && run_end) begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	// request and pending payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_type_q <= req_data.req_type;
			cur_val_q  <= req_data.value;
		end
		if (run_go && run_emit) pend_val_q <= run_val;
	end

	// set entries: shift up above the insert point, write the value at it
	for (genvar e = 0; e < DEPTH; e++) begin : g_entry
		if (e == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (ins_a && (i_q == '0)) set_a_q[e] <= cur_val_q;
				if (ins_b && (j_q == '0)) set_b_q[e] <= cur_val_q;
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (ins_a) begin
					if (CW'(e) == i_q) begin
						set_a_q[e] <= cur_val_q;
					end else if (CW'(e) > i_q) begin
						set_a_q[e] <= set_a_q[e-1];
					end
				end
				if (ins_b) begin
					if (CW'(e) == j_q) begin
						set_b_q[e] <= cur_val_q;
					end else if (CW'(e) > j_q) begin
						set_b_q[e] <= set_b_q[e-1];
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_we) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_we) rsp_q <= rsp_nxt;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

>>> src/sorted_set_operation_engine_unit.sv
// ----------------------------------------------------------------------------
// sorted_set_operation_engine_unit: sorted set union, intersection, difference
// Two sorted sets A and B of distinct signed values with ordered insert,
// set operations selected by a mode register, and membership tests in A.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per request (load A, load B, run, clear, member).
//   rsp channel: result beats; is_last marks the final beat of a request.
//   cfg channel: writes op_mode, always ready; write only while idle.
// Request handling:
//   load   : taken in idle, then a scan past the smaller entries of the set, no beats.
//   clear  : taken in idle, no beats.
//   member : taken in idle, then a scan over A, one flag beat.
//   run    : taken in idle, then a merge walk; the last beat is registered at
//            the final step. Set results stream at most one beat per merge step.
//   The merge walk goes over both sets with one element pointer each.
// A new request is taken once the current one has finished; the last beat of
// the finished one may still wait in the output register. A stalled receiver
// holds the beat and stalls the merge walk. Reset empties both sets, clears
// the overflow flag and sets op_mode to union; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_set_operation_engine_unit #(
	parameter int DEPTH = ssoe_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ssoe_pkg::req_t                req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ssoe_pkg::rsp_t                rsp_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ssoe_pkg::MODE_W-1:0]   cfg_data
);

	ssoe_pkg::cmd_t cmd;
	ssoe_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer
	ssoe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_data.req_type),
		.sts       (sts),
		.cmd       (cmd)
	);

	// set storage and merge datapath
	ssoe_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// at most one controller action per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.load_step, cmd.member_step, cmd.run_step}))
		else $error("controller issued overlapping commands");

	// a finished run leaves its final beat in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.run_done |=> rsp_valid && rsp_data.is_last)
		else $error("run finished without a last beat");

	// a membership answer is a single flag beat
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.member_done |=> rsp_valid && rsp_data.is_last && !rsp_data.empty_result &&
			(rsp_data.result_value == '0))
		else $error("membership answer malformed");

	// a run request blocks further requests until it is done
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture && (req_data.req_type == ssoe_pkg::REQ_RUN) |=> !req_ready)
		else $error("request taken during a run");

endmodule

>>> sim/ssoe_result_checker.sv
// ----------------------------------------------------------------------------
// ssoe_result_checker: result predictor and scoreboard for the set engine
// Watches the request, result and mode write channels of the sorted set
// operation engine. It keeps its own copy of both sets, the overflow flag and
// op_mode, predicts the result beats of every accepted request, and compares
// each accepted result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ssoe_result_checker #(
	parameter int DEPTH = ssoe_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  ssoe_pkg::req_t                req_data,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  ssoe_pkg::rsp_t                rsp_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ssoe_pkg::MODE_W-1:0]   cfg_data,
	input  logic                          drained,
	output int                            failures,
	output int                            pending,
	output int                            beats_checked
);

	import ssoe_pkg::*;

	localparam int SET_A      = 0;
	localparam int SET_B      = 1;
	localparam int PRINT_MAX  = 20;

	// predicted engine state
	logic signed [DATA_W-1:0] members [2][DEPTH];
	int                       fill [2];
	logic                     overflow_seen;
	logic [MODE_W-1:0]        op_mode;
	rsp_t                     expected_beats [$];
	bit                       drain_seen;

	// print one line per mismatch (up to a cap) and count it
	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (failures < PRINT_MAX) begin
			$display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
		end
		failures++;
	endtask

	function automatic bit set_holds(input int which, input logic signed [DATA_W-1:0] v);
		for (int i = 0; i < fill[which]; i++) begin
			if (members[which][i] == v) return 1'b1;
		end
		return 1'b0;
	endfunction

	// ordered insert; drop duplicates, flag overflow on a full set
	function automatic void set_insert(input int which, input logic signed [DATA_W-1:0] v);
		int pos;
		pos = 0;
		while (pos < fill[which] && members[which][pos] < v) pos++;
		if (pos < fill[which] && members[which][pos] == v) return;
		if (fill[which] >= DEPTH) begin
			overflow_seen = 1'b1;
			return;
		end
		for (int i = fill[which]; i > pos; i--) members[which][i] = members[which][i-1];
		members[which][pos] = v;
		fill[which]++;
	endfunction

	function automatic bit a_within_b();
		for (int i = 0; i < fill[SET_A]; i++) begin
			if (!set_holds(SET_B, members[SET_A][i])) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void push_beat(input logic signed [DATA_W-1:0] v, input logic flag,
			input logic empty, input logic last);
		rsp_t beat;
		beat.result_value = v;
		beat.result_flag  = flag;
		beat.empty_result = empty;
		beat.overflow     = overflow_seen;
		beat.is_last      = last;
		expected_beats.push_back(beat);
	endfunction

	// build the beats of one run request under the current op_mode
	function automatic void predict_run();
		logic signed [DATA_W-1:0] picks [$];
		logic                     flag;
		int                       i;
		int                       j;
		i = 0;
		j = 0;
		flag = 1'b0;
		if (op_mode == MODE_UNION || op_mode == MODE_INTER || op_mode == MODE_DIFF) begin
			if (op_mode == MODE_UNION) begin
				// sorted merge, common values once
				while (i < fill[SET_A] || j < fill[SET_B]) begin
					if (j >= fill[SET_B] ||
							(i < fill[SET_A] && members[SET_A][i] < members[SET_B][j])) begin
						picks.push_back(members[SET_A][i]);
						i++;
					end else if (i >= fill[SET_A] || members[SET_B][j] < members[SET_A][i]) begin
						picks.push_back(members[SET_B][j]);
						j++;
					end else begin
						picks.push_back(members[SET_A][i]);
						i++;
						j++;
					end
				end
			end else begin
				// keep A elements found in B (intersection) or absent from B (difference)
				for (i = 0; i < fill[SET_A]; i++) begin
					if (set_holds(SET_B, members[SET_A][i]) == (op_mode == MODE_INTER)) begin
						picks.push_back(members[SET_A][i]);
					end
				end
			end
			if (picks.size() == 0) begin
				push_beat('0, 1'b0, 1'b1, 1'b1);
			end else begin
				foreach (picks[k]) push_beat(picks[k], 1'b0, 1'b0, k == picks.size() - 1);
			end
		end else begin
			case (op_mode)
				MODE_SUBSET: flag = a_within_b();
				MODE_EQUAL:  flag = a_within_b() && fill[SET_A] == fill[SET_B];
				MODE_PROPER: flag = a_within_b() && fill[SET_B] > fill[SET_A];
				default:     flag = 1'b0;
			endcase
			push_beat('0, flag, 1'b0, 1'b1);
		end
	endfunction

	function automatic void predict_request(input req_t r);
		case (r.req_type)
			REQ_LOAD_A: set_insert(SET_A, r.value);
			REQ_LOAD_B: set_insert(SET_B, r.value);
			REQ_RUN:    predict_run();
			REQ_CLEAR: begin
				fill[SET_A]   = 0;
				fill[SET_B]   = 0;
				overflow_seen = 1'b0;
			end
			REQ_MEMBER: push_beat('0, set_holds(SET_A, r.value), 1'b0, 1'b1);
			default: ;  // spare request codes are dropped by the engine
		endcase
	endfunction

	task automatic check_beat(input rsp_t got);
		rsp_t want;
		if (expected_beats.size() == 0) begin
			report_mismatch("beat with nothing expected", got.result_value, '0);
			return;
		end
		want = expected_beats.pop_front();
		beats_checked++;
		if (got.result_value !== want.result_value)
			report_mismatch("result_value", got.result_value, want.result_value);
		if (got.result_flag !== want.result_flag)
			report_mismatch("result_flag", DATA_W'(got.result_flag),
				DATA_W'(want.result_flag));
		if (got.empty_result !== want.empty_result)
			report_mismatch("empty_result", DATA_W'(got.empty_result),
				DATA_W'(want.empty_result));
		if (got.overflow !== want.overflow)
			report_mismatch("overflow", DATA_W'(got.overflow), DATA_W'(want.overflow));
		if (got.is_last !== want.is_last)
			report_mismatch("is_last", DATA_W'(got.is_last), DATA_W'(want.is_last));
	endtask

	// sample every channel at the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			fill[SET_A]   = 0;
			fill[SET_B]   = 0;
			overflow_seen = 1'b0;
			op_mode       = MODE_UNION;
			expected_beats.delete();
			drain_seen    = 1'b0;
			failures      = 0;
			beats_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) op_mode = cfg_data;
			if (req_valid && req_ready) predict_request(req_data);
			if (rsp_valid && rsp_ready) check_beat(rsp_data);
			// flag predictions still open once the stimulus has drained
			if (drained && !drain_seen) begin
				drain_seen = 1'b1;
				if (expected_beats.size() != 0)
					report_mismatch("beats never delivered", expected_beats.size(), '0);
			end
		end
		pending = expected_beats.size();
	end

endmodule

>>> sim/sorted_set_operation_engine_unit_test.sv
// ----------------------------------------------------------------------------
// sorted_set_operation_engine_unit_test: regression for the sorted set engine
// Drives directed and random request streams with bursty sends, a receiver
// with shifting stall patterns and one long hold-off, writes op_mode between
// phases while idle, and takes the verdict from the result checker.
// ----------------------------------------------------------------------------
module sorted_set_operation_engine_unit_test;

	import ssoe_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
	localparam logic [REQ_W-1:0]  REQ_SPARE_5  = 3'd5;
	localparam logic [REQ_W-1:0]  REQ_SPARE_7  = 3'd7;

	localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

	localparam int REQUEST_TARGET = 350;
	localparam int SETTLE_CYCLES  = 2 * DEPTH_DEFAULT + 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int CYCLE_LIMIT    = 1000000;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_PERIODIC
	} rx_style_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	req_t                req_data;
	logic                rsp_valid;
	logic                rsp_ready;
	rsp_t                rsp_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [MODE_W-1:0]   cfg_data;
	logic                drained;

	int                  failures;
	int                  pending_beats;
	int                  beats_checked;
	int                  cycle_count;
	int                  requests_sent;
	int                  burst_left;
	bit                  gaps_on;
	bit                  hold_request;
	bit                  hold_done;
	logic [7:0]          modes_used;

	sorted_set_operation_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	ssoe_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_data      (req_data),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp_data      (rsp_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.drained       (drained),
		.failures      (failures),
		.pending       (pending_beats),
		.beats_checked (beats_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: end the run if it never drains
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// receiver: rotate through stall patterns, one long hold-off on request
	initial begin
		rx_style_t style;
		int        style_left;
		int        stall_span;
		int        tick;
		int        hold_cycles;
		rsp_ready  = 1'b0;
		style      = RX_OPEN;
		style_left = 0;
		stall_span = 1;
		tick       = 0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				rsp_ready <= 1'b0;
				hold_cycles = 0;
				while (hold_cycles < HOLD_CYCLES) begin
					@(negedge clk);
					hold_cycles++;
				end
				hold_done = 1'b1;
			end else begin
				if (style_left == 0) begin
					style      = rx_style_t'($urandom_range(RX_OPEN, RX_PERIODIC));
					style_left = $urandom_range(16, 96);
					stall_span = $urandom_range(1, 6);
				end
				style_left--;
				tick++;
				case (style)
					RX_OPEN:   rsp_ready <= 1'b1;
					RX_COIN:   rsp_ready <= $urandom_range(0, 1);
					RX_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
					default:   rsp_ready <= ((tick % 8) >= stall_span);
				endcase
			end
		end
	end

	// send one request beat, with bursts separated by random gaps
	task automatic send(input logic [REQ_W-1:0] kind, input logic signed [DATA_W-1:0] v);
		req_t beat;
		int   gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gaps_on) gap = $urandom_range(1, 8);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		beat.req_type = kind;
		beat.value    = v;
		@(negedge clk);
		req_valid <= 1'b1;
		req_data  <= beat;
		do @(posedge clk); while (!req_ready);
		if (kind <= REQ_MEMBER) requests_sent++;
	endtask

	// hold the sender until every predicted beat has arrived, then settle
	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_beats != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		modes_used[m] = 1'b1;
	endtask

	// mostly a small pool so sets overlap and repeat, sometimes extremes or wide values
	function automatic logic signed [DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll == 0) return $urandom;
		if (roll == 1) begin
			case ($urandom_range(0, 3))
				0:       return VALUE_MIN;
				1:       return VALUE_MAX;
				2:       return '0;
				default: return -1;
			endcase
		end
		return int'($urandom_range(0, 19)) - 10;
	endfunction

	// fill both sets, hit a duplicate into a full set, then overflow
	task automatic fill_phase();
		logic signed [DATA_W-1:0] first_a;
		first_a = '0;
		wait_idle();
		write_mode(MODE_UNION);
		gaps_on = 1'b1;
		send(REQ_CLEAR, pick_value());
		for (int k = 0; k < DEPTH_DEFAULT; k++) begin
			send(REQ_LOAD_A, ($urandom & 32'h0fff_ffff) | (k << 28));
			if (k == 0) first_a = req_data.value;
		end
		for (int k = 0; k < DEPTH_DEFAULT; k++) begin
			send(REQ_LOAD_B, ($urandom & 32'h0fff_ffff) | (k << 28));
		end
		send(REQ_LOAD_A, first_a);
		send(REQ_RUN, pick_value());
		send(REQ_LOAD_A, ($urandom & 32'h0fff_ffff) | 32'h7000_0000);
		send(REQ_MEMBER, first_a);
		send(REQ_RUN, pick_value());
	endtask

	// loads with runs and member tests mixed in, a little noise
	task automatic random_phase(input bit long_hold);
		logic [MODE_W-1:0] m;
		int                steps;
		int                roll;
		m = long_hold ? MODE_UNION : MODE_W'($urandom_range(MODE_UNION, MODE_SPARE_7));
		wait_idle();
		write_mode(m);
		gaps_on = ($urandom_range(0, 3) != 0);
		if (long_hold) hold_request = 1'b1;
		if ($urandom_range(0, 2) == 0) send(REQ_CLEAR, pick_value());
		steps = $urandom_range(8, 30);
		repeat (steps) begin
			roll = $urandom_range(0, 99);
			if (roll < 35)      send(REQ_LOAD_A, pick_value());
			else if (roll < 70) send(REQ_LOAD_B, pick_value());
			else if (roll < 82) send(REQ_RUN, pick_value());
			else if (roll < 92) send(REQ_MEMBER, pick_value());
			else if (roll < 95) send(REQ_CLEAR, pick_value());
			else                send(REQ_W'(REQ_SPARE_5 + $urandom_range(0, 2)), $urandom);
		end
		send(REQ_RUN, pick_value());
	endtask

	// stimulus
	initial begin
		int phases;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req_data      = '0;
		cfg_valid     = 1'b0;
		cfg_data      = MODE_UNION;
		drained       = 1'b0;
		requests_sent = 0;
		burst_left    = 0;
		gaps_on       = 1'b1;
		hold_request  = 1'b0;
		hold_done     = 1'b0;
		modes_used    = '0;
		phases        = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty union, extremes, duplicate, member hit and miss, spare codes
		wait_idle();
		write_mode(MODE_UNION);
		send(REQ_RUN, '0);
		send(REQ_LOAD_A, VALUE_MIN);
		send(REQ_LOAD_A, VALUE_MAX);
		send(REQ_LOAD_A, '0);
		send(REQ_LOAD_A, -1);
		send(REQ_LOAD_A, VALUE_MAX);
		send(REQ_LOAD_B, VALUE_MIN);
		send(REQ_LOAD_B, 5);
		send(REQ_LOAD_B, VALUE_MAX);
		send(REQ_MEMBER, VALUE_MIN);
		send(REQ_MEMBER, 7);
		for (int r = REQ_SPARE_5; r <= REQ_SPARE_7; r++) send(REQ_W'(r), $urandom);
		send(REQ_RUN, '0);
		// one run under every other mode, spare modes included
		for (int m = MODE_INTER; m <= MODE_SPARE_7; m++) begin
			wait_idle();
			write_mode(MODE_W'(m));
			send(REQ_RUN, '0);
		end
		// empty intersection after a clear
		wait_idle();
		write_mode(MODE_INTER);
		send(REQ_CLEAR, '0);
		send(REQ_RUN, '0);

		fill_phase();
		while (requests_sent < REQUEST_TARGET) begin
			random_phase(phases == 1);
			phases++;
		end

		// drain and settle, then let the checker flag anything left open
		wait_idle();
		@(negedge clk);
		drained <= 1'b1;
		@(negedge clk);
		@(negedge clk);

		$display("Sent %0d requests in %0d random phases; %0d result beats checked, %0d cycles",
			requests_sent, phases, beats_checked, cycle_count);
		$display("op_mode values written (bit per mode): %b; long receiver hold-off done: %0d",
			modes_used, hold_done);
		if (failures == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
src/ssoe_pkg.sv
src/ssoe_ctrl.sv
src/ssoe_dp.sv
src/sorted_set_operation_engine_unit.sv
sim/ssoe_result_checker.sv
sim/sorted_set_operation_engine_unit_test.sv
